### rtl/arals_pkg.sv
// types, constants and tables shared by the servo setpoint generator and its checker
package arals_pkg;

  localparam int AXES       = 6;
  localparam int FRAC_BITS  = 16;
  localparam int VAL_W      = 20;
  localparam int TABLE_AXES = 6;
  localparam int AXIS_W     = 3;
  localparam int FLAG_W     = 3;

  // constants are below 4.0 in magnitude
  localparam int CW = FRAC_BITS + 3;
  localparam int EW = ((VAL_W > CW) ? VAL_W : CW) + 1;
  localparam int WW = EW + 3;
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [AXIS_W-1:0] AXIS_OFFSET = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_NEGATE = AXIS_W'(3);

  localparam int FLAG_ACCEL  = 0;
  localparam int FLAG_SPEED  = 1;
  localparam int FLAG_BORDER = 2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [CW-1:0]    const_t;

  typedef struct packed {
    logic              command;
    logic [AXIS_W-1:0] axis;
    val_t              measured_error;
    val_t              current_position;
  } in_word_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_out;
    val_t              setpoint;
    logic [FLAG_W-1:0] limit_flags;
  } out_word_t;

  typedef struct packed {
    val_t sp;
    val_t step;
  } axis_state_t;

  // millionths to fixed point, ties away from zero
  function automatic longint to_q(longint micro);
    longint mag;
    longint r;
    mag = (micro < 0) ? -micro : micro;
    r = ((mag <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    return (micro < 0) ? -r : r;
  endfunction

  localparam const_t OFFSET0_Q = const_t'(to_q(150000));

  localparam const_t GAIN_Q [TABLE_AXES] = '{
    const_t'(to_q(100000)), const_t'(to_q(100000)), const_t'(to_q(50000)),
    const_t'(to_q(50000)),  const_t'(to_q(50000)),  const_t'(to_q(70000))
  };
  localparam const_t UPPER_Q [TABLE_AXES] = '{
    const_t'(to_q(1090000)), const_t'(to_q(150000)),  const_t'(to_q(305000)),
    const_t'(to_q(606000)),  const_t'(to_q(1570000)), const_t'(to_q(3120000))
  };
  localparam const_t LOWER_Q [TABLE_AXES] = '{
    const_t'(to_q(820000)),  const_t'(to_q(-150000)), const_t'(to_q(155000)),
    const_t'(to_q(-606000)), const_t'(to_q(1267000)), const_t'(to_q(1800000))
  };
  localparam const_t SPEED_Q [TABLE_AXES] = '{
    const_t'(to_q(10000)), const_t'(to_q(25000)), const_t'(to_q(10000)),
    const_t'(to_q(20000)), const_t'(to_q(10000)), const_t'(to_q(40000))
  };
  localparam const_t ACCEL_Q [TABLE_AXES] = '{
    const_t'(to_q(2000)),  const_t'(to_q(2000)),  const_t'(to_q(2000)),
    const_t'(to_q(20000)), const_t'(to_q(10000)), const_t'(to_q(10000))
  };

endpackage

### rtl/axis_rate_accel_limited_servo.sv
// servo setpoint generator: per-axis state memory with read-modify-write and limiting
//
//   channel | handshake             | word
//   --------+-----------------------+------------
//   in      | in_valid_i/in_stall_o  | in_word_t
//   out     | out_valid_o/out_stall_i| out_word_t
//
// one word per cycle while the output is not stalled; a word passes stage a, stage b and the output register
// stage a: gain multiply and state memory read, stage b: limiting and write back
// a write in stage b to the axis read in the same cycle is forwarded
// reset clears the per-axis valid bits at once; an unwritten axis reads as zero
// a stalled output backs up the stages and then stalls the input
module axis_rate_accel_limited_servo
  import arals_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int PW = EW + CW;
  localparam logic signed [PW-1:0] HALF_Q = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [WW-1:0] VAL_HI = WW'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] VAL_LO = WW'(-(64'sd1 <<< (VAL_W - 1)));

  // stage a
  logic     a_vld_q;
  in_word_t a_word_q;
  logic     a_go;
  logic [AXIS_W-1:0] a_tidx;
  logic [AW-1:0]     a_addr;
  logic signed [EW-1:0] a_err;
  logic signed [PW-1:0] a_prod;
  logic signed [PW-1:0] a_rnd;
  logic signed [EW-1:0] a_term;

  // stage b
  logic     b_vld_q;
  in_word_t b_word_q;
  logic signed [EW-1:0] b_term_q;
  logic     b_go;
  logic     b_in_range;
  logic [AXIS_W-1:0] b_tidx;
  logic [AW-1:0]     b_addr;

  // memory
  axis_state_t mem_q [AXES];
  logic [AXES-1:0] mem_vld_q;
  axis_state_t rd_q;
  logic        rd_vld_q;
  axis_state_t fwd_q;
  logic        fwd_hit_q;
  logic        we;
  axis_state_t wdata;

  // limiting
  axis_state_t src;
  logic signed [WW-1:0] prev, pstep, d, d2, d_acc, d_abs, d2_abs, p_abs;
  logic signed [WW-1:0] amax, vmax, lo, up, cand, cand_clamp, cand_sat, step_sat;
  logic [FLAG_W-1:0] flags;

  // output
  logic      out_vld_q;
  out_word_t out_word_q;
  out_word_t res;

  assign b_go       = b_vld_q & (~out_vld_q | ~out_stall_i);
  assign a_go       = ~b_vld_q | b_go;
  assign in_stall_o = a_vld_q & ~a_go;

  // gain term
  always_comb begin
    a_tidx = (a_word_q.axis < AXIS_W'(TABLE_AXES)) ? a_word_q.axis : '0;
    a_addr = a_word_q.axis[AW-1:0];
    a_err  = EW'(a_word_q.measured_error);
    if (a_word_q.axis == AXIS_OFFSET) begin
      a_err = EW'(a_word_q.measured_error) - EW'(OFFSET0_Q);
    end
    a_prod = PW'(a_err) * PW'(GAIN_Q[a_tidx]);
    a_rnd  = (a_prod + HALF_Q) >>> FRAC_BITS;
    a_term = a_rnd[EW-1:0];
  end

  // limit and clamp
  always_comb begin
    b_in_range = (int'(b_word_q.axis) < AXES) && (int'(b_word_q.axis) < TABLE_AXES);
    b_tidx     = b_in_range ? b_word_q.axis : '0;
    b_addr     = b_word_q.axis[AW-1:0];
    if (fwd_hit_q) begin
      src = fwd_q;
    end else if (rd_vld_q) begin
      src = rd_q;
    end else begin
      src = '0;
    end
    if (b_word_q.command) begin
      src.sp   = b_word_q.current_position;
      src.step = '0;
    end
    prev  = WW'(src.sp);
    pstep = WW'(src.step);
    amax  = WW'(ACCEL_Q[b_tidx]);
    vmax  = WW'(SPEED_Q[b_tidx]);
    lo    = WW'(LOWER_Q[b_tidx]);
    up    = WW'(UPPER_Q[b_tidx]);
    flags = '0;

    d = (b_word_q.axis == AXIS_NEGATE) ? -WW'(b_term_q) : WW'(b_term_q);
    d2     = d - pstep;
    d_abs  = (d < 0) ? -d : d;
    d2_abs = (d2 < 0) ? -d2 : d2;
    p_abs  = (pstep < 0) ? -pstep : pstep;
    d_acc  = d;
    if ((d2_abs >= amax) && (d_abs >= p_abs)) begin
      d_acc = (d >= 0) ? pstep + amax : pstep - amax;
      flags[FLAG_ACCEL] = 1'b1;
    end

    cand = prev + d_acc;
    if (d_acc >= vmax) begin
      cand = prev + vmax;
      flags[FLAG_SPEED] = 1'b1;
    end
    if (d_acc <= -vmax) begin
      cand = prev - vmax;
      flags[FLAG_SPEED] = 1'b1;
    end

    cand_clamp = cand;
    if (cand_clamp < lo) begin
      cand_clamp = lo;
      flags[FLAG_BORDER] = 1'b1;
    end
    if (cand_clamp > up) begin
      cand_clamp = up;
      flags[FLAG_BORDER] = 1'b1;
    end
    cand_sat = cand_clamp;
    if (cand_clamp > VAL_HI) begin
      cand_sat = VAL_HI;
      flags[FLAG_BORDER] = 1'b1;
    end
    if (cand_clamp < VAL_LO) begin
      cand_sat = VAL_LO;
      flags[FLAG_BORDER] = 1'b1;
    end

    step_sat = d_acc;
    if (d_acc > VAL_HI) begin
      step_sat = VAL_HI;
    end
    if (d_acc < VAL_LO) begin
      step_sat = VAL_LO;
    end

    wdata.sp   = cand_sat[VAL_W-1:0];
    wdata.step = step_sat[VAL_W-1:0];
    we         = b_go & b_in_range;

    res.axis_out    = b_word_q.axis;
    res.setpoint    = b_in_range ? wdata.sp : '0;
    res.limit_flags = b_in_range ? flags : '0;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      mem_vld_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        a_vld_q <= 1'b1;
      end else if (a_go) begin
        a_vld_q <= 1'b0;
      end
      if (a_go) begin
        b_vld_q <= a_vld_q;
      end
      if (b_go) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (we) begin
        mem_vld_q[b_addr] <= 1'b1;
      end
    end
  end

  // payload and memory
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_word_q <= in_word_i;
    end
    if (a_go && a_vld_q) begin
      b_word_q  <= a_word_q;
      b_term_q  <= a_term;
      rd_q      <= mem_q[a_addr];
      rd_vld_q  <= mem_vld_q[a_addr];
      fwd_hit_q <= we && (b_addr == a_addr);
      fwd_q     <= wdata;
    end
    if (we) begin
      mem_q[b_addr] <= wdata;
    end
    if (b_go) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/arals_checker.sv
// port-level checker for the servo setpoint generator, bound to the top level
module arals_checker
  import arals_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // input backs up only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // unknown axis gives an empty result
  a_bad_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(out_word_o.axis_out) >= TABLE_AXES)
    |-> out_word_o.setpoint == '0 && out_word_o.limit_flags == '0)
    else $error("result for unknown axis not empty");

  // border clamp lands on a border
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(out_word_o.axis_out) < TABLE_AXES)
    && out_word_o.limit_flags[FLAG_BORDER]
    |-> (out_word_o.setpoint == VAL_W'(LOWER_Q[out_word_o.axis_out]))
     || (out_word_o.setpoint == VAL_W'(UPPER_Q[out_word_o.axis_out])))
    else $error("border flag without border setpoint");

endmodule

bind axis_rate_accel_limited_servo arals_checker u_arals_checker (.*);

### tb/axis_rate_accel_limited_servo_tb.sv
// testbench for the servo setpoint generator: random and directed words checked against a predictor
module axis_rate_accel_limited_servo_tb
  import arals_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 12;

  localparam longint GAIN_MICRO  [6] = '{100000, 100000, 50000, 50000, 50000, 70000};
  localparam longint UPPER_MICRO [6] = '{1090000, 150000, 305000, 606000, 1570000, 3120000};
  localparam longint LOWER_MICRO [6] = '{820000, -150000, 155000, -606000, 1267000, 1800000};
  localparam longint SPEED_MICRO [6] = '{10000, 25000, 10000, 20000, 10000, 40000};
  localparam longint ACCEL_MICRO [6] = '{2000, 2000, 2000, 20000, 10000, 10000};
  localparam longint AXIS0_BIAS_MICRO = 150000;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  in_word_t  words_to_send [$];
  out_word_t setpoints_due [$];
  longint    axis_sp   [6];
  longint    axis_step [6];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  axis_rate_accel_limited_servo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // decimal millionths to fixed point, ties away from zero
  function automatic longint fix_of(longint micro);
    longint m;
    longint q;
    m = (micro < 0) ? -micro : micro;
    q = ((m << FRAC_BITS) + 500000) / 1000000;
    return (micro < 0) ? -q : q;
  endfunction

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint clamp_val(longint x, ref logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (VAL_W - 1)) - 1;
    lo = -(longint'(1) << (VAL_W - 1));
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic out_word_t next_setpoint(in_word_t w);
    out_word_t r;
    int ax;
    longint err, prev, pstep, term, cand, d, d2, vmax, amax;
    logic [FLAG_W-1:0] fl;
    logic hit;
    r.axis_out = w.axis;
    r.setpoint = '0;
    r.limit_flags = '0;
    if (w.axis >= AXES || w.axis >= TABLE_AXES) return r;
    ax = w.axis;
    fl = '0;
    hit = 1'b0;
    if (w.command == CMD_SEED) begin
      axis_sp[ax] = longint'(w.current_position);
      axis_step[ax] = 0;
    end
    prev = axis_sp[ax];
    pstep = axis_step[ax];
    err = longint'(w.measured_error);
    if (w.axis == AXIS_OFFSET) err = err - fix_of(AXIS0_BIAS_MICRO);
    term = (err * fix_of(GAIN_MICRO[ax]) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    cand = (w.axis == AXIS_NEGATE) ? prev - term : prev + term;
    d = cand - prev;
    d2 = d - pstep;
    amax = fix_of(ACCEL_MICRO[ax]);
    if (magnitude(d2) >= amax && magnitude(d) >= magnitude(pstep)) begin
      d = (d >= 0) ? pstep + amax : pstep - amax;
      cand = prev + d;
      fl[FLAG_ACCEL] = 1'b1;
    end
    vmax = fix_of(SPEED_MICRO[ax]);
    if (d >= vmax) begin
      cand = prev + vmax;
      fl[FLAG_SPEED] = 1'b1;
    end
    if (d <= -vmax) begin
      cand = prev - vmax;
      fl[FLAG_SPEED] = 1'b1;
    end
    if (cand < fix_of(LOWER_MICRO[ax])) begin
      cand = fix_of(LOWER_MICRO[ax]);
      fl[FLAG_BORDER] = 1'b1;
    end
    if (cand > fix_of(UPPER_MICRO[ax])) begin
      cand = fix_of(UPPER_MICRO[ax]);
      fl[FLAG_BORDER] = 1'b1;
    end
    cand = clamp_val(cand, hit);
    if (hit) fl[FLAG_BORDER] = 1'b1;
    axis_sp[ax] = cand;
    hit = 1'b0;
    axis_step[ax] = clamp_val(d, hit);
    r.setpoint = val_t'(cand);
    r.limit_flags = fl;
    return r;
  endfunction

  task automatic queue_word(logic cmd, int ax, int err, int pos);
    in_word_t w;
    w.command = cmd;
    w.axis = AXIS_W'(ax);
    w.measured_error = val_t'(err);
    w.current_position = val_t'(pos);
    words_to_send.push_back(w);
  endtask

  function automatic int any_val();
    return int'(val_t'($urandom));
  endfunction

  function automatic int rand_error();
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom_range(4000)) - 2000;
      4, 5, 6:    return int'($urandom_range(40000)) - 20000;
      7:          return int'($urandom_range(8)) - 4;
      default:    return any_val();
    endcase
  endfunction

  // position in a band a little wider than the axis borders
  function automatic int near_border(int ax);
    longint lo;
    longint hi;
    lo = fix_of(LOWER_MICRO[ax]) - 6554;
    hi = fix_of(UPPER_MICRO[ax]) + 6554;
    return int'(lo + longint'($urandom_range(int'(hi - lo))));
  endfunction

  task automatic queue_random(int n);
    int sent;
    int ax;
    int len;
    int base;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(4) == 0) begin
        queue_word(logic'($urandom_range(1)), $urandom_range(7), rand_error(),
                   ($urandom_range(1) == 1) ? any_val() : near_border($urandom_range(5)));
        sent++;
      end else begin
        ax = $urandom_range(5);
        len = $urandom_range(8, 2);
        base = int'($urandom_range(6000)) - 3000;
        if (ax == 0) base = base + int'(fix_of(AXIS0_BIAS_MICRO));
        queue_word(CMD_SEED, ax, base, near_border(ax));
        sent++;
        repeat (len) begin
          queue_word(CMD_STEP, ax, base + int'($urandom_range(400)) - 200, any_val());
          base = base + int'($urandom_range(1000)) - 500;
          sent++;
        end
      end
    end
  endtask

  task automatic drain();
    while (words_to_send.size() > 0 || in_valid_i || setpoints_due.size() > 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    logic     nv;
    in_word_t nw;
    nv = in_valid_i;
    nw = in_word_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nv = 1'b0;
      if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nw = words_to_send.pop_front();
        nv = 1'b1;
      end
    end
    in_valid_i <= nv;
    in_word_i <= nw;
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (setpoints_due.size() == 0) begin
        $display("%0t: unexpected word axis %0d setpoint %h flags %b", $time,
                 out_word_o.axis_out, out_word_o.setpoint, out_word_o.limit_flags);
        fail_count++;
      end else begin
        want = setpoints_due.pop_front();
        if (out_word_o.axis_out !== want.axis_out) begin
          $display("%0t: axis_out expected %0d got %0d", $time,
                   want.axis_out, out_word_o.axis_out);
          fail_count++;
        end
        if (out_word_o.setpoint !== want.setpoint) begin
          $display("%0t: setpoint axis %0d expected %h got %h", $time,
                   want.axis_out, want.setpoint, out_word_o.setpoint);
          fail_count++;
        end
        if (out_word_o.limit_flags !== want.limit_flags) begin
          $display("%0t: limit_flags axis %0d expected %b got %b", $time,
                   want.axis_out, want.limit_flags, out_word_o.limit_flags);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) setpoints_due.push_back(next_setpoint(in_word_i));
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("axis_rate_accel_limited_servo_tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 6; i++) begin
      axis_sp[i] = 0;
      axis_step[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 52;
    // step from reset state, before any seed
    queue_word(CMD_STEP, 1, 1000, 0);
    for (int a = 0; a < 6; a++)
      queue_word(CMD_SEED, a, 0, int'((fix_of(LOWER_MICRO[a]) + fix_of(UPPER_MICRO[a])) / 2));
    queue_word(CMD_STEP, 0, 524287, 0);
    queue_word(CMD_STEP, 0, -524288, 0);
    queue_word(CMD_STEP, 3, 524287, -524288);
    queue_word(CMD_STEP, 3, -524288, 524287);
    queue_word(CMD_STEP, 5, 3000, 0);
    queue_word(CMD_STEP, 5, 3000, 0);
    queue_word(CMD_STEP, 5, 3000, 0);
    // out-of-range axes leave the state alone
    queue_word(CMD_SEED, 6, -524288, 524287);
    queue_word(CMD_STEP, 7, 524287, -524288);
    queue_word(CMD_SEED, 2, 0, 524287);
    queue_word(CMD_SEED, 2, 0, -524288);
    queue_word(CMD_SEED, 4, 100, 91750);
    queue_word(CMD_STEP, 4, 100, 0);
    queue_word(CMD_STEP, 4, -100, 0);
    queue_word(CMD_STEP, 1, -524288, 0);
    queue_word(CMD_STEP, 1, 524287, 0);
    queue_random(330);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 9;
    queue_random(330);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(340);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && setpoints_due.size() == 0) begin
      $display("axis_rate_accel_limited_servo_tb OK");
    end else begin
      $display("axis_rate_accel_limited_servo_tb NOT OK");
    end
    $finish;
  end

endmodule
